// ----- hdl/epoch_to_calendar_assert.svh -----
// Assertion macros used by the calendar conversion RTL.
`ifndef EPOCH_TO_CALENDAR_ASSERT_SVH
`define EPOCH_TO_CALENDAR_ASSERT_SVH

// Checks that a condition holds at every rising clock edge outside reset.
`define E2C_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define E2C_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/e2c_pkg.sv -----
// Types and constants for the epoch seconds to calendar converter.
`default_nettype none
package e2c_pkg;

    localparam int unsigned EPOCH_W   = 32;
    localparam int unsigned DAYS_W    = 16;
    localparam int unsigned SUB_W     = DAYS_W + 1;

    // Reciprocals that give exact unsigned 32-bit quotients by 60 and by 24
    // as the top bits of a 64-bit product.
    localparam int unsigned PROD_W         = 2 * EPOCH_W;
    localparam logic [EPOCH_W-1:0] RECIP_60 = 32'h8888_8889;
    localparam logic [EPOCH_W-1:0] RECIP_24 = 32'hAAAA_AAAB;
    localparam int unsigned RECIP_60_SHIFT = 37;
    localparam int unsigned RECIP_24_SHIFT = 36;
    localparam int unsigned QUOT_W         = PROD_W - RECIP_24_SHIFT;

    localparam logic [5:0] SECONDS_IN_MIN = 6'd60;
    localparam logic [5:0] MINS_PER_HR    = 6'd60;
    localparam logic [5:0] HRS_PER_DAY    = 6'd24;

    localparam logic [DAYS_W-1:0] DAYS_LEAP_YEAR = 16'd366;
    localparam logic [DAYS_W-1:0] DAYS_NORM_YEAR = 16'd365;

    // Year 1970 residues modulo 4, 100 and 400.
    localparam logic [1:0] EPOCH_MOD4   = 2'd2;
    localparam logic [6:0] EPOCH_MOD100 = 7'd70;
    localparam logic [8:0] EPOCH_MOD400 = 9'd370;
    localparam logic [6:0] LAST_MOD100  = 7'd99;
    localparam logic [8:0] LAST_MOD400  = 9'd399;

    localparam logic [3:0] MONTH_FEB  = 4'd1;
    localparam logic [3:0] MONTH_LAST = 4'd11;

    typedef logic [4:0] t_month_len;

    localparam t_month_len MONTH_DAYS [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    function automatic t_month_len f_month_len(input logic [3:0] month, input logic leap);
        t_month_len len;
        if (month > MONTH_LAST) begin
            len = MONTH_DAYS[0];
        end else begin
            len = MONTH_DAYS[month];
        end
        if (month == MONTH_FEB && leap) begin
            len = 5'd29;
        end
        return len;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/epoch_to_calendar.sv -----
// Epoch seconds to calendar date and time converter, top level.
// Each request runs through three reciprocal divisions, each a product step then a
// remainder step, a walk over the year offset Y (0..136) and the month index M (0..11),
// one step per year or month and one more to end each walk, and a step to load the result.
// A new request is taken only after the last result is loaded; stalls delay the load.
// Reset is synchronous, active low, and clears the sequencer and the result valid.
`default_nettype none
`include "epoch_to_calendar_assert.svh"
module epoch_to_calendar (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [e2c_pkg::EPOCH_W-1:0]   i_epoch_seconds,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [5:0]                         o_second_of_minute,
    output logic [5:0]                         o_minute_of_hour,
    output logic [4:0]                         o_hour_of_day,
    output logic [7:0]                         o_year_offset,
    output logic [3:0]                         o_month_number,
    output logic [4:0]                         o_day_of_month
);
    import e2c_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_SEC,
        S_DIV_MIN,
        S_DIV_HR,
        S_YEAR,
        S_MONTH,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [EPOCH_W-1:0] r_acc;
    logic               r_phase;
    logic [QUOT_W-1:0]  r_quot;
    logic [5:0]         r_sec;
    logic [5:0]         r_min;
    logic [4:0]         r_hr;
    logic [7:0]         r_year;
    logic [3:0]         r_month;
    logic [1:0]         r_mod4;
    logic [6:0]         r_mod100;
    logic [8:0]         r_mod400;
    logic               r_out_valid;
    logic [5:0]         r_out_sec;
    logic [5:0]         r_out_min;
    logic [4:0]         r_out_hr;
    logic [7:0]         r_out_year;
    logic [3:0]         r_out_month;
    logic [4:0]         r_out_day;

    logic               div_mode;
    logic [5:0]         divisor;
    logic [EPOCH_W-1:0] recip;
    logic [PROD_W-1:0]  prod;
    logic [QUOT_W-1:0]  div_quot;
    logic [5:0]         quot_low;
    logic [5:0]         div_rem;
    logic               leap;
    logic [DAYS_W-1:0]  year_len;
    logic [SUB_W-1:0]   sub_a;
    logic [SUB_W-1:0]   sub_b;
    logic [SUB_W-1:0]   sub_diff;
    logic               borrow;
    logic               out_free;

    assign leap = (r_mod4 == 2'd0) && ((r_mod100 != 7'd0) || (r_mod400 == 9'd0));
    assign year_len = leap ? DAYS_LEAP_YEAR : DAYS_NORM_YEAR;

    assign div_mode = (r_state == S_DIV_SEC) || (r_state == S_DIV_MIN) ||
                      (r_state == S_DIV_HR);

    always_comb begin
        case (r_state)
            S_DIV_SEC: divisor = SECONDS_IN_MIN;
            S_DIV_MIN: divisor = MINS_PER_HR;
            default:   divisor = HRS_PER_DAY;
        endcase
    end

    // The quotient is the top of the product with a fixed reciprocal.
    assign recip    = (r_state == S_DIV_HR) ? RECIP_24 : RECIP_60;
    assign prod     = {{EPOCH_W{1'b0}}, r_acc} * {{EPOCH_W{1'b0}}, recip};
    assign div_quot = (r_state == S_DIV_HR) ? prod[PROD_W-1:RECIP_24_SHIFT]
                                            : {1'b0, prod[PROD_W-1:RECIP_60_SHIFT]};

    // The remainder is below 60, so the low six bits of the difference give it exactly.
    assign quot_low = 6'(r_quot[5:0] * divisor);

    // The one shared subtractor: division remainders, years and months.
    always_comb begin
        if (div_mode) begin
            sub_a = {{(SUB_W-6){1'b0}}, r_acc[5:0]};
            sub_b = {{(SUB_W-6){1'b0}}, quot_low};
        end else if (r_state == S_YEAR) begin
            sub_a = {1'b0, r_acc[DAYS_W-1:0]};
            sub_b = {1'b0, year_len};
        end else begin
            sub_a = {1'b0, r_acc[DAYS_W-1:0]};
            sub_b = {{(SUB_W-5){1'b0}}, f_month_len(r_month, leap)};
        end
    end

    assign sub_diff = sub_a - sub_b;
    assign borrow   = sub_diff[SUB_W-1];
    assign div_rem  = sub_diff[5:0];
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_acc    <= i_epoch_seconds;
                        r_phase  <= 1'b0;
                        r_year   <= 8'd0;
                        r_month  <= 4'd0;
                        r_mod4   <= EPOCH_MOD4;
                        r_mod100 <= EPOCH_MOD100;
                        r_mod400 <= EPOCH_MOD400;
                        r_state  <= S_DIV_SEC;
                    end
                end
                S_DIV_SEC: begin
                    if (!r_phase) begin
                        r_quot  <= div_quot;
                        r_phase <= 1'b1;
                    end else begin
                        r_sec   <= div_rem;
                        r_acc   <= {{(EPOCH_W-QUOT_W){1'b0}}, r_quot};
                        r_phase <= 1'b0;
                        r_state <= S_DIV_MIN;
                    end
                end
                S_DIV_MIN: begin
                    if (!r_phase) begin
                        r_quot  <= div_quot;
                        r_phase <= 1'b1;
                    end else begin
                        r_min   <= div_rem;
                        r_acc   <= {{(EPOCH_W-QUOT_W){1'b0}}, r_quot};
                        r_phase <= 1'b0;
                        r_state <= S_DIV_HR;
                    end
                end
                S_DIV_HR: begin
                    if (!r_phase) begin
                        r_quot  <= div_quot;
                        r_phase <= 1'b1;
                    end else begin
                        r_hr    <= div_rem[4:0];
                        r_acc   <= {{(EPOCH_W-QUOT_W){1'b0}}, r_quot};
                        r_phase <= 1'b0;
                        r_state <= S_YEAR;
                    end
                end
                S_YEAR: begin
                    if (borrow) begin
                        r_state <= S_MONTH;
                    end else begin
                        r_acc    <= {{(EPOCH_W-DAYS_W){1'b0}}, sub_diff[DAYS_W-1:0]};
                        r_year   <= r_year + 8'd1;
                        r_mod4   <= r_mod4 + 2'd1;
                        r_mod100 <= (r_mod100 == LAST_MOD100) ? 7'd0 : r_mod100 + 7'd1;
                        r_mod400 <= (r_mod400 == LAST_MOD400) ? 9'd0 : r_mod400 + 9'd1;
                    end
                end
                S_MONTH: begin
                    if (borrow || r_month == MONTH_LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_acc   <= {{(EPOCH_W-DAYS_W){1'b0}}, sub_diff[DAYS_W-1:0]};
                        r_month <= r_month + 4'd1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_sec   <= r_sec;
                        r_out_min   <= r_min;
                        r_out_hr    <= r_hr;
                        r_out_year  <= r_year;
                        r_out_month <= r_month + 4'd1;
                        r_out_day   <= r_acc[4:0] + 5'd1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall            = (r_state != S_IDLE);
    assign o_valid            = r_out_valid;
    assign o_second_of_minute = r_out_sec;
    assign o_minute_of_hour   = r_out_min;
    assign o_hour_of_day      = r_out_hr;
    assign o_year_offset      = r_out_year;
    assign o_month_number     = r_out_month;
    assign o_day_of_month     = r_out_day;

    `E2C_ASSERT_NEXT(a_busy_after_request, i_valid && !o_stall, o_stall, "accepted request did not start the sequencer")
    `E2C_ASSERT_ALWAYS(a_year_in_range, r_state != S_YEAR || r_year <= 8'd136, "year walk ran past 2106")
    `E2C_ASSERT_ALWAYS(a_date_in_range, !o_valid || (o_month_number >= 4'd1 && o_month_number <= 4'd12 && o_day_of_month != 5'd0), "result date out of range")
    `E2C_ASSERT_ALWAYS(a_time_in_range, !o_valid || (o_second_of_minute <= 6'd59 && o_minute_of_hour <= 6'd59 && o_hour_of_day <= 5'd23), "result time out of range")

endmodule
`default_nettype wire
